### hw/rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue unit.
// Depends on nothing; every other file of the block refers to it by scoped names.
`default_nettype none

package spq_pkg;

  // Field widths of one stored record.
  localparam int unsigned NUMBER_W = 16;
  localparam int unsigned NAME_W   = 8;
  localparam int unsigned PRICE_W  = 16;
  localparam int unsigned SALES_W  = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OCC_W    = 5;

  // Action codes carried by an input item.
  localparam logic ACTION_INSERT = 1'b0;
  localparam logic ACTION_REMOVE = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  // One queue record.
  typedef struct packed {
    logic [NUMBER_W-1:0] number;
    logic [NAME_W-1:0]   name;
    logic [PRICE_W-1:0]  price;
    logic [SALES_W-1:0]  sales;
  } record_t;

  // Controller states: whether the result register holds an item.
  typedef enum logic {
    ST_RES_FREE = 1'b0,
    ST_RES_HELD = 1'b1
  } ctrl_state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic    insert_en;
    logic    remove_en;
    logic    load_en;
    status_t status;
  } dp_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic empty;
    logic full;
  } dp_stat_t;

endpackage

`default_nettype wire

### hw/rtl/spq_if.sv
// Handshake interfaces for the input and result channels of the queue unit.
// Depends on spq_pkg for field widths.
`default_nettype none

interface spq_in_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [spq_pkg::NUMBER_W-1:0]  item_number;
  logic [spq_pkg::NAME_W-1:0]    item_name;
  logic [spq_pkg::PRICE_W-1:0]   item_price;
  logic [spq_pkg::SALES_W-1:0]   sales_key;

  modport source (
    output valid, action, item_number, item_name, item_price, sales_key,
    input  ready
  );
  modport sink (
    input  valid, action, item_number, item_name, item_price, sales_key,
    output ready
  );
endinterface

interface spq_out_if;
  logic                          valid;
  logic                          ready;
  logic [spq_pkg::STATUS_W-1:0]  status;
  logic [spq_pkg::NUMBER_W-1:0]  out_number;
  logic [spq_pkg::NAME_W-1:0]    out_name;
  logic [spq_pkg::PRICE_W-1:0]   out_price;
  logic [spq_pkg::SALES_W-1:0]   out_sales;
  logic [spq_pkg::OCC_W-1:0]     occupancy;

  modport source (
    output valid, status, out_number, out_name, out_price, out_sales, occupancy,
    input  ready
  );
  modport sink (
    input  valid, status, out_number, out_name, out_price, out_sales, occupancy,
    output ready
  );
endinterface

`default_nettype wire

### hw/rtl/spq_ctrl.sv
// Controller of the queue unit: handshakes and per-item commands to the datapath.
// Depends on spq_pkg for the state, command and status types.
`default_nettype none

module spq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_action,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire spq_pkg::dp_stat_t dp_stat,
  output spq_pkg::dp_cmd_t       dp_cmd
);

  spq_pkg::ctrl_state_t state_r, state_nxt;
  logic accept;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spq_pkg::ST_RES_FREE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign accept = in_valid && in_ready;

  // Next state: an accepted item fills the result register, and a new item refills it as the old one drains.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      spq_pkg::ST_RES_FREE: begin
        if (accept) state_nxt = spq_pkg::ST_RES_HELD;
      end
      spq_pkg::ST_RES_HELD: begin
        if (out_ready && !accept) state_nxt = spq_pkg::ST_RES_FREE;
      end
      default: state_nxt = spq_pkg::ST_RES_FREE;
    endcase
  end

  // Outputs: handshake signals and datapath commands.
  always_comb begin
    out_valid = 1'b0;
    in_ready  = 1'b0;
    unique case (state_r)
      spq_pkg::ST_RES_FREE: begin
        in_ready = 1'b1;
      end
      spq_pkg::ST_RES_HELD: begin
        out_valid = 1'b1;
        in_ready  = out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase

    dp_cmd.insert_en = 1'b0;
    dp_cmd.remove_en = 1'b0;
    dp_cmd.load_en   = accept;
    dp_cmd.status    = spq_pkg::STATUS_OK;
    if (accept) begin
      if (in_action == spq_pkg::ACTION_INSERT) begin
        if (dp_stat.full) dp_cmd.status = spq_pkg::STATUS_FULL;
        else              dp_cmd.insert_en = 1'b1;
      end else begin
        if (dp_stat.empty) dp_cmd.status = spq_pkg::STATUS_EMPTY;
        else               dp_cmd.remove_en = 1'b1;
      end
    end
  end

  // A queue change happens only for an accepted item, never both kinds at once.
  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    !(dp_cmd.insert_en && dp_cmd.remove_en))
    else $error("insert and remove issued together");

  a_no_insert_full: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.insert_en |-> !dp_stat.full)
    else $error("insert issued into a full queue");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.load_en |=> out_valid)
    else $error("accepted item produced no result");

endmodule

`default_nettype wire

### hw/rtl/spq_datapath.sv
// Datapath of the queue unit: a row of sorted record cells, the count and the result register.
// Depends on spq_pkg for the record and command types.
`default_nettype none

module spq_datapath #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire spq_pkg::dp_cmd_t                dp_cmd,
  output spq_pkg::dp_stat_t                    dp_stat,
  input  wire spq_pkg::record_t                in_rec,
  output logic [spq_pkg::STATUS_W-1:0]         res_status,
  output spq_pkg::record_t                     res_rec,
  output logic [spq_pkg::OCC_W-1:0]            res_occ
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  spq_pkg::record_t ent_r   [CAPACITY];
  spq_pkg::record_t ent_nxt [CAPACITY];
  logic [CAPACITY-1:0] le;
  logic [CW-1:0] count_r, count_nxt;
  logic [31:0] count_ext;
  spq_pkg::status_t status_r;
  spq_pkg::record_t res_r;
  logic [spq_pkg::OCC_W-1:0] occ_r;

  assign dp_stat.empty = (count_r == '0);
  assign dp_stat.full  = (count_r == CW'(CAPACITY));

  // Each cell compares its key with the new one; the held cells with keys not
  // above the new key form a prefix, and the new record lands right after it.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign le[i] = (CW'(i) < count_r) && (ent_r[i].sales <= in_rec.sales);

    always_comb begin
      ent_nxt[i] = ent_r[i];
      if (dp_cmd.insert_en) begin
        if (le[i]) begin
          ent_nxt[i] = ent_r[i];
        end else begin
          if (i == 0) begin
            ent_nxt[i] = in_rec;
          end else if (le[(i == 0) ? 0 : i - 1]) begin
            ent_nxt[i] = in_rec;
          end else begin
            ent_nxt[i] = ent_r[(i == 0) ? 0 : i - 1];
          end
        end
      end else if (dp_cmd.remove_en) begin
        // Every record moves one place toward the head.
        ent_nxt[i] = ent_r[(i == CAPACITY - 1) ? i : i + 1];
      end
    end

    always_ff @(posedge clk) begin
      if (dp_cmd.insert_en || dp_cmd.remove_en) begin
        ent_r[i] <= ent_nxt[i];
      end
    end
  end

  // Record count.
  always_comb begin
    count_nxt = count_r;
    if (dp_cmd.insert_en)      count_nxt = count_r + CW'(1);
    else if (dp_cmd.remove_en) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign count_ext = 32'(count_nxt);

  // Result register: the head record on a remove, zeros otherwise.
  always_ff @(posedge clk) begin
    if (dp_cmd.load_en) begin
      status_r <= dp_cmd.status;
      res_r    <= dp_cmd.remove_en ? ent_r[0] : '0;
      occ_r    <= count_ext[spq_pkg::OCC_W-1:0];
    end
  end

  assign res_status = status_r;
  assign res_rec    = res_r;
  assign res_occ    = occ_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("record count above capacity");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.insert_en |=> count_r == $past(count_r) + CW'(1))
    else $error("insert did not raise the count");

  a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.remove_en |=> count_r == $past(count_r) - CW'(1))
    else $error("remove did not lower the count");

endmodule

`default_nettype wire

### hw/rtl/sorted_priority_queue_unit.sv
// Sorted priority queue unit: a bounded queue of records kept in ascending key order.
// A result is shown in the cycle after its item is accepted.
// Throughput: one item per cycle while the result side is ready; every cell compares and shifts in parallel.
// The result register lets a new item in while the last result is being taken.
// Reset (rst_n low, synchronous) empties the queue; no clearing pass is needed.
// Depends on spq_pkg, spq_if, spq_ctrl and spq_datapath.
`default_nettype none

module sorted_priority_queue_unit #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  spq_in_if.sink      in_ch,
  spq_out_if.source   out_ch
);

  spq_pkg::dp_cmd_t  dp_cmd;
  spq_pkg::dp_stat_t dp_stat;
  spq_pkg::record_t  in_rec;
  spq_pkg::record_t  res_rec;

  // Input record assembled from the channel fields.
  assign in_rec.number = in_ch.item_number;
  assign in_rec.name   = in_ch.item_name;
  assign in_rec.price  = in_ch.item_price;
  assign in_rec.sales  = in_ch.sales_key;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_action (in_ch.action),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .dp_stat   (dp_stat),
    .dp_cmd    (dp_cmd)
  );

  spq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .dp_cmd     (dp_cmd),
    .dp_stat    (dp_stat),
    .in_rec     (in_rec),
    .res_status (out_ch.status),
    .res_rec    (res_rec),
    .res_occ    (out_ch.occupancy)
  );

  // Result record onto the channel fields.
  assign out_ch.out_number = res_rec.number;
  assign out_ch.out_name   = res_rec.name;
  assign out_ch.out_price  = res_rec.price;
  assign out_ch.out_sales  = res_rec.sales;

endmodule

`default_nettype wire

### verif/spq_result_checker.sv
// Result checker for the sorted priority queue unit: predicts every result and compares it.
// Depends on spq_pkg for record and status types and on spq_if for the two channels.
`timescale 1ns / 100ps

module spq_result_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  spq_in_if           in_ch,
  spq_out_if          out_ch,
  output int unsigned errors,
  output int unsigned pending
);

  localparam int unsigned REPORT_LIMIT = 10;

  // One result as the block should show it.
  typedef struct packed {
    spq_pkg::status_t             status;
    spq_pkg::record_t             rec;
    logic [spq_pkg::OCC_W-1:0]    occupancy;
  } queue_result_t;

  // Predicted queue contents, kept sorted by sales key, oldest first among equal keys.
  spq_pkg::record_t held [CAPACITY];
  logic [15:0]      held_count;

  queue_result_t    expected_results [$];
  int unsigned      reported;

  // Applies one accepted item to the predicted queue and works out its result.
  task automatic predict_item(input logic act, input spq_pkg::record_t rec,
                              output queue_result_t res);
    int pos;
    int i;
    res        = '0;
    res.status = spq_pkg::STATUS_OK;
    if (act == spq_pkg::ACTION_INSERT) begin
      if (held_count >= CAPACITY) begin
        res.status = spq_pkg::STATUS_FULL;
      end else begin
        // The new record goes after every record with an equal or smaller key.
        pos = 0;
        while (pos < held_count && held[pos].sales <= rec.sales) pos++;
        for (i = held_count; i > pos; i--) held[i] = held[i-1];
        held[pos]  = rec;
        held_count = held_count + 1;
      end
    end else begin
      if (held_count == 0) begin
        res.status = spq_pkg::STATUS_EMPTY;
      end else begin
        res.rec = held[0];
        for (i = 1; i < held_count; i++) held[i-1] = held[i];
        held_count = held_count - 1;
      end
    end
    res.occupancy = held_count[spq_pkg::OCC_W-1:0];
  endtask

  // Results are checked before new items are predicted; a result never shows in
  // the cycle its item is accepted.
  always @(posedge clk) begin : watch_channels
    queue_result_t    got;
    queue_result_t    want;
    spq_pkg::record_t incoming;
    if (!rst_n) begin
      held_count = 0;
      expected_results.delete();
      errors   <= 0;
      pending  <= 0;
      reported = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.status     = spq_pkg::status_t'(out_ch.status);
        got.rec.number = out_ch.out_number;
        got.rec.name   = out_ch.out_name;
        got.rec.price  = out_ch.out_price;
        got.rec.sales  = out_ch.out_sales;
        got.occupancy  = out_ch.occupancy;
        if (expected_results.size() == 0) begin
          errors <= errors + 1;
          if (reported < REPORT_LIMIT) begin
            $display("%0t: result with no item outstanding: status %0d number %h",
                     $realtime, got.status, got.rec.number);
            reported++;
          end
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status || got.rec.number !== want.rec.number ||
              got.rec.name !== want.rec.name || got.rec.price !== want.rec.price ||
              got.rec.sales !== want.rec.sales || got.occupancy !== want.occupancy) begin
            errors <= errors + 1;
            if (reported < REPORT_LIMIT) begin
              $display("%0t: expected status %0d number %h name %h price %h sales %h occ %0d",
                       $realtime, want.status, want.rec.number, want.rec.name,
                       want.rec.price, want.rec.sales, want.occupancy);
              $display("%0t:      got status %0d number %h name %h price %h sales %h occ %0d",
                       $realtime, got.status, got.rec.number, got.rec.name,
                       got.rec.price, got.rec.sales, got.occupancy);
              reported++;
            end
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        incoming.number = in_ch.item_number;
        incoming.name   = in_ch.item_name;
        incoming.price  = in_ch.item_price;
        incoming.sales  = in_ch.sales_key;
        predict_item(in_ch.action, incoming, want);
        expected_results.push_back(want);
      end
      pending <= expected_results.size();
    end
  end

endmodule

### verif/testbench.sv
// Top of the sorted priority queue testbench: clock, reset, item stimulus and verdict.
// Depends on spq_pkg, spq_if, sorted_priority_queue_unit and spq_result_checker.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned CAPACITY     = 16;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned SEGMENTS     = 19;
  localparam int unsigned SEGMENT_LEN  = 100;
  localparam int unsigned MAX_GAP      = 17;

  // Key ranges used by the random part.
  localparam int KEYS_NARROW  = 0;
  localparam int KEYS_FULL    = 1;
  localparam int KEYS_EXTREME = 2;

  logic        clk;
  logic        rst_n;
  int unsigned errors;
  int unsigned pending;
  int unsigned idle_cycles;
  bit          sender_steady;

  spq_in_if  in_ch ();
  spq_out_if out_ch ();

  sorted_priority_queue_unit #(.CAPACITY(CAPACITY)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  spq_result_checker #(.CAPACITY(CAPACITY)) result_check (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .errors  (errors),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Count cycles in which no item moves on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= STALL_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // Offers one item after a random gap, or none while the sender is steady, and waits until the block takes it.
  task automatic send_item(input logic act, input logic [15:0] num, input logic [7:0] nm,
                           input logic [15:0] pr, input logic [15:0] key);
    int gap;
    gap = sender_steady ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.action      <= act;
    in_ch.item_number <= num;
    in_ch.item_name   <= nm;
    in_ch.item_price  <= pr;
    in_ch.sales_key   <= key;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stops offering items until every predicted result has come out.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // Result side: random stalls, calm stretches, and two long hold-offs.
  initial begin : result_sink
    int          gap;
    int unsigned taken;
    bit          steady;
    taken  = 0;
    steady = 1'b0;
    out_ch.ready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 63) == 0) steady = !steady;
      if (taken == 400 || taken == 1300) begin
        gap = HOLD_CYCLES;
      end else begin
        gap = steady ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      taken++;
      @(negedge clk);
    end
  end

  initial begin : stimulus
    logic [15:0] seed_keys [16];
    logic [31:0] word_a;
    logic [31:0] word_b;
    logic [15:0] key;
    logic        act;
    int          insert_pct;
    int          key_mode;
    int          seg;
    int          n;
    int          i;

    seed_keys = '{16'hFFFF, 16'h0000, 16'd5, 16'd5, 16'hFFFF, 16'd3, 16'h0000, 16'd100,
                  16'd5, 16'h8000, 16'd1, 16'hFFFE, 16'd7, 16'd7, 16'd200, 16'd2};
    sender_steady     = 1'b0;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.action      = spq_pkg::ACTION_INSERT;
    in_ch.item_number = '0;
    in_ch.item_name   = '0;
    in_ch.item_price  = '0;
    in_ch.sales_key   = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: remove from an empty queue, with every record field set high.
    send_item(spq_pkg::ACTION_REMOVE, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF);

    // Fill the queue: extreme fields, extreme keys and several equal keys.
    send_item(spq_pkg::ACTION_INSERT, 16'hFFFF, 8'hFF, 16'hFFFF, seed_keys[0]);
    send_item(spq_pkg::ACTION_INSERT, 16'h0000, 8'h00, 16'h0000, seed_keys[1]);
    for (i = 2; i < 16; i++) begin
      send_item(spq_pkg::ACTION_INSERT, 16'(i), 8'(8'h41 + i), 16'(i * 100), seed_keys[i]);
    end

    // A full queue refuses the record.
    send_item(spq_pkg::ACTION_INSERT, 16'h1234, 8'h5A, 16'h4321, 16'h0000);

    // Removes ignore the record fields they carry.
    for (i = 0; i < 4; i++) begin
      word_a = $urandom;
      word_b = $urandom;
      send_item(spq_pkg::ACTION_REMOVE, word_a[15:0], word_a[23:16], word_b[15:0],
                word_b[31:16]);
    end
    send_item(spq_pkg::ACTION_INSERT, 16'hA5A5, 8'h3C, 16'h5A5A, 16'd5);
    drain_results();

    // Random: segments with their own insert share, key range and pacing.
    for (seg = 0; seg < SEGMENTS; seg++) begin
      case ($urandom_range(0, 4))
        0:       insert_pct = 90;
        1:       insert_pct = 70;
        2:       insert_pct = 50;
        3:       insert_pct = 30;
        default: insert_pct = 10;
      endcase
      key_mode      = $urandom_range(KEYS_NARROW, KEYS_EXTREME);
      sender_steady = ($urandom_range(0, 3) == 0);
      if (seg == 6 || seg == 13) drain_results();
      for (n = 0; n < SEGMENT_LEN; n++) begin
        word_a = $urandom;
        word_b = $urandom;
        act = ($urandom_range(0, 99) < insert_pct) ? spq_pkg::ACTION_INSERT
                                                   : spq_pkg::ACTION_REMOVE;
        case (key_mode)
          KEYS_NARROW: key = 16'($urandom_range(0, 7));
          KEYS_FULL:   key = word_b[31:16];
          default: begin
            case ($urandom_range(0, 3))
              0:       key = 16'h0000;
              1:       key = 16'h0001;
              2:       key = 16'hFFFE;
              default: key = 16'hFFFF;
            endcase
          end
        endcase
        send_item(act, word_a[15:0], word_a[23:16], word_b[15:0], key);
      end
    end

    // Wait for the last results and for anything unexpected, then give the verdict.
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
